@@ hdl/quaternion_to_rotation_matrix_top_macros.svh @@
// Assertion macros for the quaternion to rotation matrix block.
// Used by the port checker; depends on nothing else.
`ifndef QUATERNION_TO_ROTATION_MATRIX_TOP_MACROS_SVH
`define QUATERNION_TO_ROTATION_MATRIX_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define QRM_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define QRM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/qrm_pkg.sv @@
// Shared types and constants for the quaternion to rotation matrix block.
// No dependencies.
package qrm_pkg;

   localparam int QW    = 24;      // quaternion component width
   localparam int PW    = 48;      // product width
   localparam int NW    = 50;      // signed numerator / norm sum width
   localparam int MW    = 49;      // magnitude and divisor width
   localparam int RW    = 50;      // partial remainder width
   localparam int OW    = 16;      // matrix entry width
   localparam int QB    = 16;      // quotient bits
   localparam int LANES = 9;       // matrix entries

   localparam logic [OW-1:0] ONE_Q14 = 16'd16384;

   typedef struct packed {
      logic signed [QW-1:0] quat_w;
      logic signed [QW-1:0] quat_x;
      logic signed [QW-1:0] quat_y;
      logic signed [QW-1:0] quat_z;
   } req_type;

   typedef struct packed {
      logic signed [OW-1:0] m00;
      logic signed [OW-1:0] m01;
      logic signed [OW-1:0] m02;
      logic signed [OW-1:0] m10;
      logic signed [OW-1:0] m11;
      logic signed [OW-1:0] m12;
      logic signed [OW-1:0] m20;
      logic signed [OW-1:0] m21;
      logic signed [OW-1:0] m22;
      logic                 degenerate;
   } rsp_type;

   // One divider stage: nine lanes sharing the squared norm as divisor
   typedef struct packed {
      logic                        valid;
      logic                        degen;
      logic [MW-1:0]               den;
      logic [LANES-1:0][RW-1:0]    rem;
      logic [LANES-1:0][QB-1:0]    quo;
      logic [LANES-1:0]            neg;
   } div_type;

endpackage

@@ hdl/quaternion_to_rotation_matrix_top.sv @@
// Channel | Direction | Payload           | Handshake
// req_    | in        | qrm_pkg::req_type | req_valid / req_stall
// rsp_    | out       | qrm_pkg::rsp_type | rsp_valid / rsp_stall
// One quaternion per cycle while the output is not stalled; a result passes
// three front stages (products, sums, magnitudes), sixteen divider stages
// (one quotient bit each) and the output register.
// Synchronous active-high reset empties the pipe. A stalled output register
// freezes the whole pipe, and req_stall rises only then.
module quaternion_to_rotation_matrix_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  qrm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output qrm_pkg::rsp_type rsp_data
);

   logic             advance;
   qrm_pkg::div_type front_div, back_div;

   // Advance unless a held result is blocked
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   qrm_front u_front (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (req_valid),
      .in_data  (req_data),
      .out_div  (front_div)
   );

   qrm_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .in_div  (front_div),
      .out_div (back_div)
   );

   qrm_round u_round (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_div    (back_div),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

endmodule

@@ hdl/qrm_front.sv @@
// Front end: products, numerator sums, magnitudes over three register stages.
// Depends on qrm_pkg.
module qrm_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             in_valid,
   input  qrm_pkg::req_type in_data,
   output qrm_pkg::div_type out_div
);

   logic signed [qrm_pkg::PW-1:0] ww_ff, xx_ff, yy_ff, zz_ff;
   logic signed [qrm_pkg::PW-1:0] xy_ff, xz_ff, yz_ff, wx_ff, wy_ff, wz_ff;
   logic                          v1_ff, v2_ff, v3_ff;
   logic signed [qrm_pkg::NW-1:0] n2_ff;
   logic signed [qrm_pkg::NW-1:0] num_ff [qrm_pkg::LANES];
   logic signed [qrm_pkg::NW-1:0] num_in [qrm_pkg::LANES];
   logic signed [qrm_pkg::NW-1:0] n2_in;
   logic signed [qrm_pkg::NW-1:0] eww, exx, eyy, ezz, exy, exz, eyz, ewx, ewy, ewz;
   qrm_pkg::div_type              div_ff, div_in;

   // Sign-extend products to the sum width
   assign eww = {{2{ww_ff[qrm_pkg::PW-1]}}, ww_ff};
   assign exx = {{2{xx_ff[qrm_pkg::PW-1]}}, xx_ff};
   assign eyy = {{2{yy_ff[qrm_pkg::PW-1]}}, yy_ff};
   assign ezz = {{2{zz_ff[qrm_pkg::PW-1]}}, zz_ff};
   assign exy = {{2{xy_ff[qrm_pkg::PW-1]}}, xy_ff};
   assign exz = {{2{xz_ff[qrm_pkg::PW-1]}}, xz_ff};
   assign eyz = {{2{yz_ff[qrm_pkg::PW-1]}}, yz_ff};
   assign ewx = {{2{wx_ff[qrm_pkg::PW-1]}}, wx_ff};
   assign ewy = {{2{wy_ff[qrm_pkg::PW-1]}}, wy_ff};
   assign ewz = {{2{wz_ff[qrm_pkg::PW-1]}}, wz_ff};

   // Form the homogeneous numerators and the squared norm
   always_comb begin
      n2_in     = eww + exx + eyy + ezz;
      num_in[0] = eww + exx - eyy - ezz;
      num_in[1] = (exy - ewz) <<< 1;
      num_in[2] = (exz + ewy) <<< 1;
      num_in[3] = (exy + ewz) <<< 1;
      num_in[4] = eww - exx + eyy - ezz;
      num_in[5] = (eyz - ewx) <<< 1;
      num_in[6] = (exz - ewy) <<< 1;
      num_in[7] = (eyz + ewx) <<< 1;
      num_in[8] = eww - exx - eyy + ezz;
   end

   // Split into sign and magnitude, load the divider's first stage
   always_comb begin
      div_in       = '0;
      div_in.valid = v2_ff;
      div_in.degen = (n2_ff == '0);
      div_in.den   = n2_ff[qrm_pkg::MW-1:0];
      for (int i = 0; i < qrm_pkg::LANES; i++) begin
         div_in.neg[i] = num_ff[i][qrm_pkg::NW-1];
         div_in.rem[i] = num_ff[i][qrm_pkg::NW-1] ? qrm_pkg::RW'(-num_ff[i])
                                                  : qrm_pkg::RW'(num_ff[i]);
      end
   end

   // Control: valid bits advance with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // Payload: products, sums, magnitudes
   always_ff @(posedge clock) begin
      if (advance) begin
         ww_ff  <= in_data.quat_w * in_data.quat_w;
         xx_ff  <= in_data.quat_x * in_data.quat_x;
         yy_ff  <= in_data.quat_y * in_data.quat_y;
         zz_ff  <= in_data.quat_z * in_data.quat_z;
         xy_ff  <= in_data.quat_x * in_data.quat_y;
         xz_ff  <= in_data.quat_x * in_data.quat_z;
         yz_ff  <= in_data.quat_y * in_data.quat_z;
         wx_ff  <= in_data.quat_w * in_data.quat_x;
         wy_ff  <= in_data.quat_w * in_data.quat_y;
         wz_ff  <= in_data.quat_w * in_data.quat_z;
         n2_ff  <= n2_in;
         num_ff <= num_in;
         div_ff <= div_in;
      end
   end

   always_comb begin
      out_div       = div_ff;
      out_div.valid = v3_ff;
   end

endmodule

@@ hdl/qrm_divider.sv @@
// Pipelined restoring divider: one quotient bit per stage for nine lanes.
// Depends on qrm_pkg.
module qrm_divider (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  qrm_pkg::div_type in_div,
   output qrm_pkg::div_type out_div
);

   qrm_pkg::div_type stage_ff [qrm_pkg::QB+1];
   qrm_pkg::div_type stage_in [qrm_pkg::QB];

   always_comb stage_ff[0] = in_div;

   for (genvar k = 0; k < qrm_pkg::QB; k++) begin : g_step
      // Shift (all but the first stage), trial subtract, keep the bit
      always_comb begin
         logic [qrm_pkg::RW-1:0] shifted;
         logic                   ge;
         stage_in[k] = stage_ff[k];
         for (int i = 0; i < qrm_pkg::LANES; i++) begin
            shifted = (k == 0) ? stage_ff[k].rem[i]
                               : {stage_ff[k].rem[i][qrm_pkg::RW-2:0], 1'b0};
            ge = shifted >= {1'b0, stage_ff[k].den};
            stage_in[k].rem[i] = ge ? shifted - {1'b0, stage_ff[k].den} : shifted;
            stage_in[k].quo[i] = {stage_ff[k].quo[i][qrm_pkg::QB-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            stage_ff[k+1].valid <= 1'b0;
         end else if (advance) begin
            stage_ff[k+1].valid <= stage_in[k].valid;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            stage_ff[k+1].degen <= stage_in[k].degen;
            stage_ff[k+1].den   <= stage_in[k].den;
            stage_ff[k+1].rem   <= stage_in[k].rem;
            stage_ff[k+1].quo   <= stage_in[k].quo;
            stage_ff[k+1].neg   <= stage_in[k].neg;
         end
      end
   end

   assign out_div = stage_ff[qrm_pkg::QB];

endmodule

@@ hdl/qrm_round.sv @@
// Output stage: round, saturate, restore sign, identity for a zero quaternion.
// Depends on qrm_pkg.
module qrm_round (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  qrm_pkg::div_type in_div,
   output logic             out_valid,
   output qrm_pkg::rsp_type out_data
);

   logic             valid_ff;
   qrm_pkg::rsp_type rsp_ff, rsp_in;
   logic [qrm_pkg::OW-1:0] ent [qrm_pkg::LANES];

   // Round half away from zero on the magnitude, then clamp
   always_comb begin
      logic [qrm_pkg::QB:0]   inc;
      logic [qrm_pkg::OW-1:0] mag;
      for (int i = 0; i < qrm_pkg::LANES; i++) begin
         inc = {1'b0, in_div.quo[i]} + 1'b1;
         mag = inc[qrm_pkg::QB:1];
         if (mag > qrm_pkg::ONE_Q14) mag = qrm_pkg::ONE_Q14;
         if (in_div.degen) ent[i] = (i % 4 == 0) ? qrm_pkg::ONE_Q14 : '0;
         else              ent[i] = in_div.neg[i] ? -mag : mag;
      end
   end

   always_comb begin
      rsp_in.m00        = ent[0];
      rsp_in.m01        = ent[1];
      rsp_in.m02        = ent[2];
      rsp_in.m10        = ent[3];
      rsp_in.m11        = ent[4];
      rsp_in.m12        = ent[5];
      rsp_in.m20        = ent[6];
      rsp_in.m21        = ent[7];
      rsp_in.m22        = ent[8];
      rsp_in.degenerate = in_div.degen;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_div.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = rsp_ff;

endmodule

@@ hdl/qrm_checker.sv @@
// Port checker for the quaternion to rotation matrix block, bound to the top.
// Depends on qrm_pkg and the assertion macro header.
`include "quaternion_to_rotation_matrix_top_macros.svh"

module qrm_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input qrm_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input qrm_pkg::rsp_type rsp_data
);

   // Hold a blocked result
   `QRM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "blocked result changed")

   // Stall the input only while the output is blocked
   `QRM_ASSERT_NOW(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall, "input stalled without blocked output")

   // Degenerate flag carries the identity diagonal and zero m01, m12 and m20
   `QRM_ASSERT_NOW(a_degen_ident, clock, reset, rsp_valid && rsp_data.degenerate, rsp_data.m00 == qrm_pkg::ONE_Q14 && rsp_data.m11 == qrm_pkg::ONE_Q14 && rsp_data.m22 == qrm_pkg::ONE_Q14 && rsp_data.m01 == '0 && rsp_data.m12 == '0 && rsp_data.m20 == '0, "degenerate result is not identity")

   // Diagonal entry m00 stays within plus or minus one
   `QRM_ASSERT_NOW(a_diag_range, clock, reset, rsp_valid, $signed(rsp_data.m00) <= 16384 && $signed(rsp_data.m00) >= -16384, "diagonal entry out of range")

endmodule

bind quaternion_to_rotation_matrix_top qrm_checker u_qrm_checker (.*);
